>>> rtl/core/uca_pkg.sv
// ----------------------------------------------------------------------------
// uca_pkg: shared types and constants of the command line assembler
// command codes, result status codes, character constants and defaults
// ----------------------------------------------------------------------------
`default_nettype none

package uca_pkg;

  localparam int RING_DEPTH_DEF  = 256;
  localparam int CHUNK_LIMIT_DEF = 64;
  localparam int RING_MARGIN     = 2;
  localparam int QUEUE_DEPTH     = 4;

  localparam int CAP_W  = 7;
  localparam int EMIT_W = 7;
  localparam int CNT_W  = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET = 7'd65;
  localparam logic [CAP_W-1:0]  CAP_MIN   = 7'd2;
  localparam logic [EMIT_W-1:0] MAX_EMIT  = 7'd64;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // input mode codes
  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_IDLE    = 2'd1;
  localparam logic [1:0] MODE_REQUEST = 2'd2;
  localparam logic [1:0] MODE_ERROR   = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_NONE  = 2'd0;
  localparam logic [1:0] STATUS_BYTE  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_IDLE,
    OP_REQUEST,
    OP_ERROR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] data;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/uca_if.sv
// ----------------------------------------------------------------------------
// uca_if: channel interfaces of the command line assembler
// command input, line result output and capacity register write
// ----------------------------------------------------------------------------
`default_nettype none

interface uca_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;
  modport source (output valid, mode, rx_byte, input ready);
  modport sink   (input valid, mode, rx_byte, output ready);
endinterface

interface uca_line_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [7:0]                line_byte;
  logic                      last;
  logic [uca_pkg::CNT_W-1:0] dropped_total;
  logic [uca_pkg::CNT_W-1:0] error_total;
  modport source (output valid, status, line_byte, last, dropped_total, error_total,
                  input ready);
  modport sink   (input valid, status, line_byte, last, dropped_total, error_total,
                  output ready);
endinterface

interface uca_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [uca_pkg::CAP_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/uca_front.sv
// ----------------------------------------------------------------------------
// uca_front: input stage
// accepts input beats, decodes the mode into a command and holds it
// ----------------------------------------------------------------------------
`default_nettype none

module uca_front (
  input  wire logic          clk,
  input  wire logic          rst,
  uca_cmd_if.sink            cmd,
  output logic               cmd_valid,
  output uca_pkg::cmd_t      cmd_word,
  input  wire logic          cmd_ready
);

  logic          held;
  uca_pkg::cmd_t decoded;

  always_comb begin
    decoded.data = cmd.rx_byte;
    case (cmd.mode)
      uca_pkg::MODE_BYTE:    decoded.op = uca_pkg::OP_BYTE;
      uca_pkg::MODE_IDLE:    decoded.op = uca_pkg::OP_IDLE;
      uca_pkg::MODE_REQUEST: decoded.op = uca_pkg::OP_REQUEST;
      default:               decoded.op = uca_pkg::OP_ERROR;
    endcase
  end

  assign cmd.ready = !held || cmd_ready;
  assign cmd_valid = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (cmd.ready) begin
      held <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      cmd_word <= decoded;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/uca_cmd_queue.sv
// ----------------------------------------------------------------------------
// uca_cmd_queue: command queue
// short fifo between the input stage and the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module uca_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  input  wire uca_pkg::cmd_t push_word,
  output logic               push_ready,
  output logic               pop_valid,
  output uca_pkg::cmd_t      pop_word,
  input  wire logic          pop_ready
);

  localparam int AW = $clog2(uca_pkg::QUEUE_DEPTH);
  localparam int NW = $clog2(uca_pkg::QUEUE_DEPTH + 1);
  localparam logic [NW-1:0] FULL = NW'(uca_pkg::QUEUE_DEPTH);

  uca_pkg::cmd_t slots [uca_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count != FULL;
  assign pop_valid  = count != '0;
  assign pop_word   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_word;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/uca_back.sv
// ----------------------------------------------------------------------------
// uca_back: sequencer
// chunk buffer, byte ring, commit, line scan, pop and result register
// ----------------------------------------------------------------------------
`default_nettype none

module uca_back #(
  parameter int RING_DEPTH  = uca_pkg::RING_DEPTH_DEF,
  parameter int CHUNK_LIMIT = uca_pkg::CHUNK_LIMIT_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [uca_pkg::CAP_W-1:0] line_capacity,
  input  wire logic                      q_valid,
  input  wire uca_pkg::cmd_t             q_word,
  output logic                           q_ready,
  uca_line_if.source                     line
);

  localparam int PW  = $clog2(RING_DEPTH);
  localparam int FW  = $clog2(RING_DEPTH + 1);
  localparam int CW  = (CHUNK_LIMIT > 1) ? $clog2(CHUNK_LIMIT) : 1;
  localparam int CCW = $clog2(CHUNK_LIMIT + 1);
  localparam int MW  = (FW > uca_pkg::EMIT_W) ? FW : uca_pkg::EMIT_W;
  localparam logic [FW-1:0]  DEPTH_F    = FW'(RING_DEPTH);
  localparam logic [FW-1:0]  NEAR_FULL  = FW'(RING_DEPTH - uca_pkg::RING_MARGIN);
  localparam logic [PW-1:0]  LAST_PTR   = PW'(RING_DEPTH - 1);
  localparam logic [CCW-1:0] CHUNK_FULL = CCW'(CHUNK_LIMIT);

  typedef enum logic [3:0] {
    S_IDLE,
    S_COMMIT_RD,
    S_COMMIT_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_POP_RD,
    S_POP_OUT,
    S_TERM,
    S_LF_RD,
    S_LF_CHK,
    S_FINISH,
    S_REPLY_NONE
  } state_t;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  // storage
  logic [7:0] ring_mem  [RING_DEPTH];
  logic [7:0] chunk_mem [CHUNK_LIMIT];
  logic [7:0] ring_q;
  logic [7:0] chunk_q;

  // sequencer registers
  state_t                    state;
  logic [PW-1:0]             rp;
  logic [PW-1:0]             wp;
  logic [FW-1:0]             fill;
  logic                      seg;
  logic [CCW-1:0]            chunk_n;
  logic [CCW-1:0]            commit_i;
  logic [uca_pkg::CNT_W-1:0] drop_cnt;
  logic [uca_pkg::CNT_W-1:0] err_cnt;
  logic [PW-1:0]             scan_ptr;
  logic [FW-1:0]             scan_i;
  logic [FW-1:0]             line_n;
  logic                      found;
  logic                      term_cr;
  logic [uca_pkg::EMIT_W-1:0] emit_n;
  logic [uca_pkg::EMIT_W-1:0] copied;
  logic [FW-1:0]             pop_j;

  // result register
  logic                      res_valid;
  logic [1:0]                res_status;
  logic [7:0]                res_byte;
  logic                      res_last;
  logic [uca_pkg::CNT_W-1:0] res_drop;
  logic [uca_pkg::CNT_W-1:0] res_err;

  // combinational control
  logic                       slot_free;
  logic                       res_load;
  logic                       ring_we;
  logic                       ring_re;
  logic [PW-1:0]              ring_raddr;
  logic                       chunk_we;
  logic                       chunk_re;
  logic [uca_pkg::CAP_W-1:0]  cap_m1;
  logic [uca_pkg::EMIT_W-1:0] limit;
  logic [MW-1:0]              emit_w;

  assign slot_free = !res_valid || line.ready;
  assign q_ready   = state == S_IDLE;

  assign line.valid         = res_valid;
  assign line.status        = res_status;
  assign line.line_byte     = res_byte;
  assign line.last          = res_last;
  assign line.dropped_total = res_drop;
  assign line.error_total   = res_err;

  always_comb begin
    cap_m1 = line_capacity - 7'd1;
    limit  = (cap_m1 > uca_pkg::MAX_EMIT) ? uca_pkg::MAX_EMIT : cap_m1;
    emit_w = (MW'(line_n) < MW'(limit)) ? MW'(line_n) : MW'(limit);
  end

  // a new result beat goes into the result register this cycle
  always_comb begin
    case (state)
      S_POP_OUT:    res_load = slot_free && (copied < emit_n);
      S_FINISH:     res_load = slot_free && (emit_n == '0);
      S_REPLY_NONE: res_load = slot_free;
      default:      res_load = 1'b0;
    endcase
  end

  always_comb begin
    ring_we    = (state == S_COMMIT_WR) && (fill < DEPTH_F);
    chunk_we   = (state == S_IDLE) && q_valid && (q_word.op == uca_pkg::OP_BYTE);
    chunk_re   = state == S_COMMIT_RD;
    ring_re    = 1'b0;
    ring_raddr = rp;
    case (state)
      S_SCAN_RD: begin
        ring_re    = 1'b1;
        ring_raddr = scan_ptr;
      end
      S_POP_RD, S_LF_RD: begin
        ring_re = 1'b1;
      end
      default: begin
        ring_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wp] <= chunk_q;
    end
    if (ring_re) begin
      ring_q <= ring_mem[ring_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (chunk_we) begin
      chunk_mem[chunk_n[CW-1:0]] <= q_word.data;
    end
    if (chunk_re) begin
      chunk_q <= chunk_mem[commit_i[CW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rp        <= '0;
      wp        <= '0;
      fill      <= '0;
      seg       <= 1'b0;
      chunk_n   <= '0;
      drop_cnt  <= '0;
      err_cnt   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (line.ready && !res_load) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_word.op)
              uca_pkg::OP_BYTE: begin
                chunk_n <= chunk_n + 1'b1;
                if (CCW'(chunk_n + 1'b1) == CHUNK_FULL) begin
                  commit_i <= '0;
                  state    <= S_COMMIT_RD;
                end
              end
              uca_pkg::OP_IDLE: begin
                if (chunk_n != '0) begin
                  commit_i <= '0;
                  state    <= S_COMMIT_RD;
                end
              end
              uca_pkg::OP_REQUEST: begin
                if (line_capacity < uca_pkg::CAP_MIN || fill == '0) begin
                  state <= S_REPLY_NONE;
                end else begin
                  scan_ptr <= rp;
                  scan_i   <= '0;
                  found    <= 1'b0;
                  state    <= S_SCAN_RD;
                end
              end
              default: begin
                err_cnt <= err_cnt + 1'b1;
                chunk_n <= '0;
              end
            endcase
          end
        end
        S_COMMIT_RD: begin
          state <= S_COMMIT_WR;
        end
        S_COMMIT_WR: begin
          if (fill < DEPTH_F) begin
            wp   <= wrap_inc(wp);
            fill <= fill + 1'b1;
          end else begin
            drop_cnt <= drop_cnt + 1'b1;
          end
          commit_i <= commit_i + 1'b1;
          if (CCW'(commit_i + 1'b1) == chunk_n) begin
            chunk_n <= '0;
            seg     <= 1'b1;
            state   <= S_IDLE;
          end else begin
            state <= S_COMMIT_RD;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (ring_q == uca_pkg::CH_CR || ring_q == uca_pkg::CH_LF) begin
            found   <= 1'b1;
            term_cr <= ring_q == uca_pkg::CH_CR;
            line_n  <= scan_i;
            state   <= S_DECIDE;
          end else begin
            scan_ptr <= wrap_inc(scan_ptr);
            scan_i   <= scan_i + 1'b1;
            if (FW'(scan_i + 1'b1) == fill) begin
              line_n <= fill;
              state  <= S_DECIDE;
            end else begin
              state <= S_SCAN_RD;
            end
          end
        end
        S_DECIDE: begin
          if (!found && !seg && fill < NEAR_FULL) begin
            state <= S_REPLY_NONE;
          end else begin
            emit_n <= uca_pkg::EMIT_W'(emit_w);
            copied <= '0;
            pop_j  <= '0;
            state  <= (line_n == '0) ? S_TERM : S_POP_RD;
          end
        end
        S_POP_RD: begin
          state <= S_POP_OUT;
        end
        S_POP_OUT: begin
          if (copied >= emit_n || slot_free) begin
            if (copied < emit_n) begin
              res_valid  <= 1'b1;
              res_status <= uca_pkg::STATUS_BYTE;
              res_byte   <= ring_q;
              res_last   <= uca_pkg::EMIT_W'(copied + 1'b1) == emit_n;
              res_drop   <= drop_cnt;
              res_err    <= err_cnt;
              copied     <= copied + 1'b1;
            end
            rp    <= wrap_inc(rp);
            fill  <= fill - 1'b1;
            pop_j <= pop_j + 1'b1;
            state <= (FW'(pop_j + 1'b1) == line_n) ? S_TERM : S_POP_RD;
          end
        end
        S_TERM: begin
          if (found) begin
            rp   <= wrap_inc(rp);
            fill <= fill - 1'b1;
            // a cr may be followed by an lf that belongs to the same ending
            state <= (term_cr && fill != FW'(1)) ? S_LF_RD : S_FINISH;
          end else begin
            state <= S_FINISH;
          end
        end
        S_LF_RD: begin
          state <= S_LF_CHK;
        end
        S_LF_CHK: begin
          if (ring_q == uca_pkg::CH_LF) begin
            rp   <= wrap_inc(rp);
            fill <= fill - 1'b1;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (emit_n != '0 || slot_free) begin
            if (fill == '0) begin
              seg <= 1'b0;
            end else if (found) begin
              seg <= 1'b1;
            end
            if (emit_n == '0) begin
              res_valid  <= 1'b1;
              res_status <= uca_pkg::STATUS_EMPTY;
              res_byte   <= '0;
              res_last   <= 1'b1;
              res_drop   <= drop_cnt;
              res_err    <= err_cnt;
            end
            state <= S_IDLE;
          end
        end
        S_REPLY_NONE: begin
          if (slot_free) begin
            res_valid  <= 1'b1;
            res_status <= uca_pkg::STATUS_NONE;
            res_byte   <= '0;
            res_last   <= 1'b1;
            res_drop   <= drop_cnt;
            res_err    <= err_cnt;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= DEPTH_F)
    else $error("ring fill level beyond depth");

  a_pointers_meet: assert property (@(posedge clk) disable iff (rst)
    (fill == '0 || fill == DEPTH_F) |-> rp == wp)
    else $error("ring pointers disagree with fill level");

  a_chunk_committed: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> chunk_n < CHUNK_FULL)
    else $error("full chunk left uncommitted");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP_OUT) |-> copied <= emit_n)
    else $error("more line bytes emitted than allowed");
`endif

endmodule

`default_nettype wire

>>> rtl/core/uart_command_line_assembler_unit.sv
// ----------------------------------------------------------------------------
// uart_command_line_assembler_unit: line buffered uart receive assembler
// collects received bytes into chunks and a byte ring, hands out whole lines
// ----------------------------------------------------------------------------
// Received bytes, receive-idle events, receive errors and line requests come
// in on the cmd channel, one per beat. The input stage takes a beat in every
// cycle while the four-entry command queue has room, so the sender is only
// held up when the sequencer falls behind. The sequencer takes one command
// per cycle while it is idle: a byte, an idle with nothing pending or an
// error is handled in the idle state; committing a chunk reads each chunk
// byte from the chunk buffer and then writes it into the ring. A line request
// is taken, then decided, and is otherwise bound by the single read port of
// the ring: each byte scanned up to and including the terminator is read and
// then checked, each byte popped from the line is read and then sent, then
// come the terminator, the trailing lf and the final status, plus any waits
// for the line channel to take a result beat. Each request answers with one
// or more result beats, the last marked by last. The ring needs no clearing
// pass after reset. The line capacity register is written through cfg and
// must only change while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_command_line_assembler_unit #(
  parameter int RING_DEPTH  = uca_pkg::RING_DEPTH_DEF,
  parameter int CHUNK_LIMIT = uca_pkg::CHUNK_LIMIT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  uca_cmd_if.sink   cmd,
  uca_line_if.source line,
  uca_cfg_if.sink   cfg
);

  // line capacity register, always ready to take a write beat
  logic [uca_pkg::CAP_W-1:0] line_capacity;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_capacity <= uca_pkg::CAP_RESET;
    end else if (cfg.valid) begin
      line_capacity <= cfg.data;
    end
  end

  // front: decoded command from the input stage into the queue
  logic          fr_valid;
  uca_pkg::cmd_t fr_word;
  logic          fr_ready;

  // queue to sequencer
  logic          q_valid;
  uca_pkg::cmd_t q_word;
  logic          q_ready;

  uca_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (fr_valid),
    .cmd_word  (fr_word),
    .cmd_ready (fr_ready)
  );

  // decouples input acceptance from the long running line requests
  uca_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_word  (fr_word),
    .push_ready (fr_ready),
    .pop_valid  (q_valid),
    .pop_word   (q_word),
    .pop_ready  (q_ready)
  );

  // back: chunk buffer, ring, scan and pop, registered result beat
  uca_back #(
    .RING_DEPTH  (RING_DEPTH),
    .CHUNK_LIMIT (CHUNK_LIMIT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .line_capacity (line_capacity),
    .q_valid       (q_valid),
    .q_word        (q_word),
    .q_ready       (q_ready),
    .line          (line)
  );

endmodule

`default_nettype wire
